// ===== sv/stall_detect_moving_avg_hysteresis_defines.svh =====
// assertion macros of the stall detector checker
`ifndef STALL_DETECT_MOVING_AVG_HYSTERESIS_DEFINES_SVH
`define STALL_DETECT_MOVING_AVG_HYSTERESIS_DEFINES_SVH

// checked only while out of reset, expects clk and rst_n in scope
`define SDMAH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// checked at every edge, reset included
`define SDMAH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/sdmah_pkg.sv =====
// shared widths, defaults and mode change codes of the stall detector
`timescale 1ns / 1ps
`default_nettype none

package sdmah_pkg;

  localparam int VEL_W      = 16;
  localparam int SPEED_W    = 16;
  localparam int MODE_W     = 2;
  localparam int WINDOW_DEF = 100;

  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WIGGLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MOVE   = 2'd2;

endpackage

`default_nettype wire

// ===== sv/stall_detect_moving_avg_hysteresis.sv =====
// stall detector: speed norm, moving average over a ring memory, hysteresis flag
//
//  channel  dir  handshake           payload
//  in       in   in_valid/in_stall   in_vel_x, in_vel_y, in_vel_z
//  out      out  out_valid/out_stall out_stuck, out_mode_change, out_avg_speed
//  cfg      in   cfg_valid/cfg_ready cfg_speed_threshold
//
// one item at a time; steps: take it, square the three axes on one multiplier,
// bit-serial square root, ring update, scaling, reciprocal divide, output
// a finished item waits in the output register; the core stops at its last step
// only while that register is still full and stalled
// synchronous active-low reset; a wrap flag makes unwritten ring entries read as zero
`timescale 1ns / 1ps
`default_nettype none

module stall_detect_moving_avg_hysteresis #(
  parameter int WINDOW = sdmah_pkg::WINDOW_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire signed [sdmah_pkg::VEL_W-1:0]   in_vel_x,
  input  wire signed [sdmah_pkg::VEL_W-1:0]   in_vel_y,
  input  wire signed [sdmah_pkg::VEL_W-1:0]   in_vel_z,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_stuck,
  output logic [sdmah_pkg::MODE_W-1:0]     out_mode_change,
  output logic [sdmah_pkg::SPEED_W-1:0]    out_avg_speed,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [sdmah_pkg::SPEED_W-1:0]    cfg_speed_threshold
);

  localparam int VEL_W   = sdmah_pkg::VEL_W;
  localparam int SPEED_W = sdmah_pkg::SPEED_W;
  localparam int SQ_W    = 2 * VEL_W;
  localparam int REM_W   = SPEED_W + 2;
  localparam int CNT_W   = $clog2(SPEED_W);
  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int SUM_W   = SPEED_W + SLOT_W;
  localparam int LIM_W   = $clog2(11 * WINDOW) + SPEED_W;
  localparam int RSH     = SUM_W + SLOT_W;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;

  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(SPEED_W - 1);
  localparam logic [CNT_W-1:0]  SQ_LAST   = CNT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
  localparam logic [LIM_W-1:0]  LO_K      = LIM_W'(9 * WINDOW);
  localparam logic [LIM_W-1:0]  HI_K      = LIM_W'(11 * WINDOW);
  localparam logic [LIM_W-1:0]  TEN       = LIM_W'(10);
  // ceil(2^RSH / WINDOW), exact floor quotient for every reachable sum
  localparam logic [RECIP_W-1:0] RECIP    =
    RECIP_W'(((64'd1 << RSH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQ   = 7'b0000010,
    S_ROOT = 7'b0000100,
    S_UPD  = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  // control state
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                full_r, full_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                stuck_r, stuck_nxt;
  logic [SPEED_W-1:0]  thr_r, thr_nxt;
  logic                out_valid_r, out_valid_nxt;

  // datapath
  logic signed [VEL_W-1:0] vel_x_r, vel_x_nxt;
  logic signed [VEL_W-1:0] vel_y_r, vel_y_nxt;
  logic signed [VEL_W-1:0] vel_z_r, vel_z_nxt;
  logic [SQ_W-1:0]     rad_r, rad_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [SPEED_W-1:0]  root_r, root_nxt;
  logic [SPEED_W-1:0]  quo_r, quo_nxt;
  logic [LIM_W-1:0]    s10_r, s10_nxt;
  logic [LIM_W-1:0]    lo_r, lo_nxt;
  logic [LIM_W-1:0]    hi_r, hi_nxt;
  logic                out_stuck_r, out_stuck_nxt;
  logic [sdmah_pkg::MODE_W-1:0] out_mode_r, out_mode_nxt;
  logic [SPEED_W-1:0]  out_avg_r, out_avg_nxt;

  // ring memory
  logic [SPEED_W-1:0]  ring_mem [WINDOW];
  logic [SPEED_W-1:0]  rd_data_r;
  logic                ring_we;

  // scratch
  logic signed [VEL_W-1:0] sq_sel;
  logic [VEL_W-1:0]    sq_mag;
  logic [SQ_W-1:0]     sq_prod;
  logic [REM_W-1:0]    rem_shift;
  logic [REM_W-1:0]    trial;
  logic [PROD_W-1:0]   quo_prod;
  logic [SPEED_W-1:0]  old_speed;
  logic                in_acc;
  logic                out_load;
  logic                flag_new;

  assign in_stall        = (state_r != S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_stuck       = out_stuck_r;
  assign out_mode_change = out_mode_r;
  assign out_avg_speed   = out_avg_r;

  always_comb begin
    // one axis squared per cycle on a shared multiplier
    case (cnt_r)
      CNT_W'(0): sq_sel = vel_x_r;
      CNT_W'(1): sq_sel = vel_y_r;
      default:   sq_sel = vel_z_r;
    endcase
    sq_mag  = sq_sel[VEL_W-1] ? VEL_W'(~sq_sel + VEL_W'(1)) : VEL_W'(sq_sel);
    sq_prod = SQ_W'(sq_mag) * SQ_W'(sq_mag);

    rem_shift = {rem_r[REM_W-3:0], rad_r[SQ_W-1:SQ_W-2]};
    trial     = {root_r, 2'b01};

    quo_prod = PROD_W'(sum_r) * PROD_W'(RECIP);

    old_speed = full_r ? rd_data_r : '0;

    in_acc   = in_valid && !in_stall;
    out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

    // hysteresis: raise below 90 percent, clear above 110 percent
    if (!stuck_r && (s10_r < lo_r)) begin
      flag_new = 1'b1;
    end else if (stuck_r && (s10_r > hi_r)) begin
      flag_new = 1'b0;
    end else begin
      flag_new = stuck_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    slot_nxt      = slot_r;
    full_nxt      = full_r;
    sum_nxt       = sum_r;
    stuck_nxt     = stuck_r;
    thr_nxt       = thr_r;
    out_valid_nxt = out_valid_r;
    vel_x_nxt     = vel_x_r;
    vel_y_nxt     = vel_y_r;
    vel_z_nxt     = vel_z_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    quo_nxt       = quo_r;
    s10_nxt       = s10_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_stuck_nxt = out_stuck_r;
    out_mode_nxt  = out_mode_r;
    out_avg_nxt   = out_avg_r;
    ring_we       = 1'b0;

    if (cfg_valid) begin
      thr_nxt = cfg_speed_threshold;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          vel_x_nxt = in_vel_x;
          vel_y_nxt = in_vel_y;
          vel_z_nxt = in_vel_z;
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        rad_nxt = (cnt_r == CNT_W'(0)) ? sq_prod : rad_r + sq_prod;
        if (cnt_r == SQ_LAST) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          root_nxt  = '0;
          state_nxt = S_ROOT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_ROOT: begin
        // one result bit per cycle, two radicand bits consumed
        rad_nxt = {rad_r[SQ_W-3:0], 2'b00};
        if (rem_shift >= trial) begin
          rem_nxt  = rem_shift - trial;
          root_nxt = {root_r[SPEED_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_shift;
          root_nxt = {root_r[SPEED_W-2:0], 1'b0};
        end
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_UPD;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      S_UPD: begin
        // old entry was read during the root, same slot written back now
        ring_we = 1'b1;
        sum_nxt = sum_r - SUM_W'(old_speed) + SUM_W'(root_r);
        if (slot_r == SLOT_LAST) begin
          slot_nxt = '0;
          full_nxt = 1'b1;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        s10_nxt   = LIM_W'(sum_r) * TEN;
        lo_nxt    = LIM_W'(thr_r) * LO_K;
        hi_nxt    = LIM_W'(thr_r) * HI_K;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // divide by WINDOW as a multiply by its rounded-up reciprocal
        quo_nxt   = quo_prod[RSH +: SPEED_W];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          // a flag edge is a mode switch: a rise gives WIGGLE, a fall MOVE, else NONE
          stuck_nxt     = flag_new;
          out_stuck_nxt = flag_new;
          if (!stuck_r && flag_new) begin
            out_mode_nxt = sdmah_pkg::MODE_WIGGLE;
          end else if (stuck_r && !flag_new) begin
            out_mode_nxt = sdmah_pkg::MODE_MOVE;
          end else begin
            out_mode_nxt = sdmah_pkg::MODE_NONE;
          end
          out_avg_nxt   = quo_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      slot_r      <= '0;
      full_r      <= 1'b0;
      sum_r       <= '0;
      stuck_r     <= 1'b0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      slot_r      <= slot_nxt;
      full_r      <= full_nxt;
      sum_r       <= sum_nxt;
      stuck_r     <= stuck_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vel_x_r     <= vel_x_nxt;
    vel_y_r     <= vel_y_nxt;
    vel_z_r     <= vel_z_nxt;
    rad_r       <= rad_nxt;
    rem_r       <= rem_nxt;
    root_r      <= root_nxt;
    quo_r       <= quo_nxt;
    s10_r       <= s10_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    out_stuck_r <= out_stuck_nxt;
    out_mode_r  <= out_mode_nxt;
    out_avg_r   <= out_avg_nxt;
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[slot_r] <= root_r;
    end
    rd_data_r <= ring_mem[slot_r];
  end

endmodule

`default_nettype wire

// ===== sv/sdmah_checker.sv =====
// port-level checks of the stall detector and their bind
`timescale 1ns / 1ps
`default_nettype none

`include "stall_detect_moving_avg_hysteresis_defines.svh"

module sdmah_checker (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           in_valid,
  input wire                           in_stall,
  input wire                           out_valid,
  input wire                           out_stall,
  input wire                           out_stuck,
  input wire [sdmah_pkg::MODE_W-1:0]   out_mode_change,
  input wire [sdmah_pkg::SPEED_W-1:0]  out_avg_speed
);

  logic       last_stuck_r;
  logic [1:0] pending_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // flag of the last delivered item and items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_stuck_r <= 1'b0;
      pending_r    <= '0;
    end else begin
      if (out_acc) begin
        last_stuck_r <= out_stuck;
      end
      if (in_acc && !out_acc) begin
        pending_r <= pending_r + 2'd1;
      end else if (out_acc && !in_acc) begin
        pending_r <= pending_r - 2'd1;
      end
    end
  end

  `SDMAH_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "out_valid after reset")
  `SDMAH_ASSERT(a_mode_matches_flag, (out_valid && (out_mode_change == sdmah_pkg::MODE_WIGGLE) |-> out_stuck) and (out_valid && (out_mode_change == sdmah_pkg::MODE_MOVE) |-> !out_stuck), "mode change disagrees with flag")
  `SDMAH_ASSERT(a_flag_needs_change, out_acc && (out_mode_change == sdmah_pkg::MODE_NONE) |-> out_stuck == last_stuck_r, "flag moved without a mode change")
  `SDMAH_ASSERT(a_no_phantom_item, (pending_r <= 2'd2) && (!out_valid || (pending_r != 2'd0)), "result count disagrees with items taken")
  `SDMAH_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_avg_speed), "stalled result changed")

endmodule

bind stall_detect_moving_avg_hysteresis sdmah_checker u_sdmah_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_stuck       (out_stuck),
  .out_mode_change (out_mode_change),
  .out_avg_speed   (out_avg_speed)
);

`default_nettype wire
